/* rtl/core/rsbd_pkg.sv */
// ----------------------------------------------------------------------------
// rsbd_pkg
// Shared constants, types and controller interface of the range-sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsbd_pkg;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned BLOCK_SIZE  = 32;
  localparam int unsigned BLOCK_COUNT = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned BLK_W   = $clog2(BLOCK_SIZE);
  localparam int unsigned BIDX_W  = $clog2(BLOCK_COUNT);
  localparam int unsigned BI_W    = IDX_W - BLK_W;
  localparam int unsigned IN_W    = OP_W + 2 * IDX_W + DATA_W;
  localparam int unsigned IN_TD_W = ((IN_W + 7) / 8) * 8;

  localparam logic [IDX_W-1:0] COUNT_RESET = IDX_W'(DEPTH);
  localparam logic [IDX_W-1:0] COUNT_MAX   = IDX_W'(DEPTH);

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_WR,
    ST_WALK_A,
    ST_WAIT_A,
    ST_WALK_B,
    ST_WALK_C,
    ST_WAIT_C,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;      // latch input transfer, clear accumulator
    logic load_wr;      // write element and add to block sum
    logic add_rd;       // read element at left index
    logic add_wr;       // write back element plus value
    logic ptr_left;     // element pointer from left index
    logic ptr_tail;     // element pointer to start of right edge block
    logic walk_rd;      // read element at pointer, advance
    logic blk_load;     // block pointer to first inner block
    logic blk_add;      // accumulate block sum, advance
    logic emit;         // load result register
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic upd_err;
    logic qry_err;
    logic empty;
    logic mid_busy;     // at least one whole block between the edges
    logic tail_busy;    // right edge block holds elements
    logic last_a;
    logic last_c;
    logic blk_last;
    logic out_full;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/range_sum_block_decomposition.sv */
// ----------------------------------------------------------------------------
// range_sum_block_decomposition
// Element array with per-block running sums; load, add and range sum query.
// ----------------------------------------------------------------------------
// load and add update the store; errors and empty queries skip to the result
// query: walks the left edge elements, then the whole blocks, then the right edge
//   elements, one store read or block sum per cycle
// one item at a time; the next transfer is taken while a result waits in the
//   output register
// reset: block sums cleared at once, element count 1024, element store unset
`default_nettype none

module range_sum_block_decomposition import rsbd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [IDX_W-1:0]   cfg_wdata_i,    // element_count
  input  wire logic               s_axis_tvalid_i,
  output      logic               s_axis_tready_o,
  // op [1:0], left_index [12:2], right_end [23:13], value [87:24]
  input  wire logic [IN_TD_W-1:0] s_axis_tdata_i,
  output      logic               m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output      logic [DATA_W-1:0]  m_axis_tdata_o,  // range_sum [63:0]
  output      logic               m_axis_tuser_o   // range_error [0]
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  rsbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rsbd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_sum_o     (m_axis_tdata_o),
    .m_err_o     (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

/* rtl/core/rsbd_ram.sv */
// ----------------------------------------------------------------------------
// rsbd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/rsbd_datapath.sv */
// ----------------------------------------------------------------------------
// rsbd_datapath
// Element store, block sums, pointers, accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbd_datapath import rsbd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_wdata_i,
  input  wire logic [IN_TD_W-1:0] in_data_i,
  input  wire ctl_cmd_t          cmd_i,
  output      dp_stat_t          stat_o,
  input  wire logic              m_tready_i,
  output      logic              m_tvalid_o,
  output      logic [DATA_W-1:0] m_sum_o,
  output      logic              m_err_o
);

  logic [IDX_W-1:0]  count_q;
  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  left_q, right_q;
  logic [DATA_W-1:0] value_q;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [BIDX_W-1:0] bptr_q, bptr_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              rvalid_q;
  logic [DATA_W-1:0] bsum_q [BLOCK_COUNT];
  logic              m_valid_q, m_valid_d;
  logic [DATA_W-1:0] m_sum_q;
  logic              m_err_q;

  logic [IDX_W-1:0]  eff_count;
  logic [BI_W-1:0]   lb, rb;
  logic              same_blk;
  logic [IDX_W-1:0]  end_a, tail_start;
  logic              res_err;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic [BIDX_W-1:0] upd_blk;
  logic [DATA_W-1:0] addend;

  assign eff_count  = (count_q > COUNT_MAX) ? COUNT_MAX : count_q;
  assign lb         = left_q[IDX_W-1:BLK_W];
  assign rb         = right_q[IDX_W-1:BLK_W];
  assign same_blk   = (lb == rb);
  assign end_a      = same_blk ? right_q : {lb + BI_W'(1), {BLK_W{1'b0}}};
  assign tail_start = {rb, {BLK_W{1'b0}}};
  assign upd_blk    = left_q[ADDR_W-1:BLK_W];

  always_comb begin
    stat_o           = '0;
    stat_o.op        = op_q;
    stat_o.upd_err   = (left_q >= eff_count);
    stat_o.qry_err   = (left_q > eff_count) || (right_q > eff_count);
    stat_o.empty     = (left_q >= right_q);
    stat_o.mid_busy  = ((lb + BI_W'(1)) < rb);
    stat_o.tail_busy = !same_blk && (tail_start != right_q);
    stat_o.last_a    = ((ptr_q + IDX_W'(1)) == end_a);
    stat_o.last_c    = ((ptr_q + IDX_W'(1)) == right_q);
    stat_o.blk_last  = ((BI_W'(bptr_q) + BI_W'(1)) == rb);
    stat_o.out_full  = m_valid_q && !m_tready_i;
  end

  // element store
  assign ram_we    = cmd_i.load_wr || cmd_i.add_wr;
  assign ram_re    = cmd_i.walk_rd || cmd_i.add_rd;
  assign ram_raddr = cmd_i.add_rd ? left_q[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];
  assign ram_wdata = cmd_i.add_wr ? (ram_rdata + value_q) : value_q;

  rsbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (left_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // one addend a cycle: element read data or the current block sum
  always_comb begin
    if (rvalid_q) begin
      addend = ram_rdata;
    end else if (cmd_i.blk_add) begin
      addend = bsum_q[bptr_q];
    end else begin
      addend = '0;
    end
    acc_d = cmd_i.capture ? '0 : acc_q + addend;
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_left) begin
      ptr_d = left_q;
    end else if (cmd_i.ptr_tail) begin
      ptr_d = tail_start;
    end else if (cmd_i.walk_rd) begin
      ptr_d = ptr_q + IDX_W'(1);
    end
    bptr_d = bptr_q;
    if (cmd_i.blk_load) begin
      bptr_d = lb[BIDX_W-1:0] + BIDX_W'(1);
    end else if (cmd_i.blk_add) begin
      bptr_d = bptr_q + BIDX_W'(1);
    end
  end

  assign res_err   = (op_q == OP_QUERY) ? stat_o.qry_err : stat_o.upd_err;
  assign m_valid_d = cmd_i.emit ? 1'b1 : (m_valid_q && !m_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= COUNT_RESET;
      rvalid_q  <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        bsum_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      rvalid_q  <= cmd_i.walk_rd;
      m_valid_q <= m_valid_d;
      if (cmd_i.load_wr || cmd_i.add_wr) begin
        bsum_q[upd_blk] <= bsum_q[upd_blk] + value_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_data_i[OP_W-1:0];
      left_q  <= in_data_i[OP_W +: IDX_W];
      right_q <= in_data_i[OP_W+IDX_W +: IDX_W];
      value_q <= in_data_i[OP_W+2*IDX_W +: DATA_W];
    end
    acc_q  <= acc_d;
    ptr_q  <= ptr_d;
    bptr_q <= bptr_d;
    if (cmd_i.emit) begin
      m_sum_q <= res_err ? '0 : acc_q;
      m_err_q <= res_err;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_sum_o    = m_sum_q;
  assign m_err_o    = m_err_q;

endmodule

`default_nettype wire

/* rtl/core/rsbd_ctrl.sv */
// ----------------------------------------------------------------------------
// rsbd_ctrl
// Sequencer for load, add and range query walks.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbd_ctrl import rsbd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire dp_stat_t stat_i,
  output      ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat_i.op)
          OP_LOAD:  state_d = stat_i.upd_err ? ST_EMIT : ST_IDLE;
          OP_ADD:   state_d = stat_i.upd_err ? ST_EMIT : ST_ADD_WR;
          OP_QUERY: state_d = (stat_i.qry_err || stat_i.empty) ? ST_EMIT : ST_WALK_A;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_ADD_WR: state_d = ST_IDLE;
      ST_WALK_A: begin
        if (stat_i.last_a) state_d = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (stat_i.mid_busy) begin
          state_d = ST_WALK_B;
        end else if (stat_i.tail_busy) begin
          state_d = ST_WALK_C;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_WALK_B: begin
        if (stat_i.blk_last) state_d = stat_i.tail_busy ? ST_WALK_C : ST_EMIT;
      end
      ST_WALK_C: begin
        if (stat_i.last_c) state_d = ST_WAIT_C;
      end
      ST_WAIT_C: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!stat_i.out_full) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.load_wr  = (stat_i.op == OP_LOAD) && !stat_i.upd_err;
        cmd_o.add_rd   = (stat_i.op == OP_ADD) && !stat_i.upd_err;
        cmd_o.ptr_left = 1'b1;
      end
      ST_ADD_WR: cmd_o.add_wr = 1'b1;
      ST_WALK_A: cmd_o.walk_rd = 1'b1;
      ST_WAIT_A: begin
        // last edge element lands in the accumulator here
        cmd_o.ptr_tail = 1'b1;
        cmd_o.blk_load = 1'b1;
      end
      ST_WALK_B: cmd_o.blk_add = 1'b1;
      ST_WALK_C: cmd_o.walk_rd = 1'b1;
      ST_WAIT_C: ;
      ST_EMIT:   cmd_o.emit = !stat_i.out_full;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* tb/range_sum_block_decomposition_tb.sv */
// ----------------------------------------------------------------------------
// range_sum_block_decomposition_tb
// Drives load, add, range sum query and unused op transfers into the block under
// several element counts, each result checked against a table value or a cycle-free
// predictor holding its elements and block sums. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module range_sum_block_decomposition_tb;
  import rsbd_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;
  localparam int unsigned     LAT_PAUSE = 120;
  localparam int unsigned     MAX_SHOWN = 10;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              err;
  } sum_result_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum bit {CHK_MODEL, CHK_FIXED} row_chk_e;

  typedef struct {
    row_kind_e         kind;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
    logic [DATA_W-1:0] value;
    row_chk_e          chk;
    logic [DATA_W-1:0] x_sum;
    logic              x_err;
  } dir_row_t;

  // cfg rows carry the new element count in the left field
  dir_row_t dir_tab [] = '{
    '{ROW_ITEM, OP_QUERY, 11'd0, 11'd0, 64'd0, CHK_FIXED, 64'd0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 11'd1024, 11'd1024, 64'd0, CHK_FIXED, 64'd0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 11'd700, 11'd300, 64'd0, CHK_FIXED, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd1024, 11'd0, 64'd5, CHK_FIXED, 64'd0, 1'b1},
    '{ROW_ITEM, OP_ADD, 11'd1024, 11'd1024, 64'hffff_ffff_ffff_ffff, CHK_FIXED, 64'd0, 1'b1},
    '{ROW_ITEM, OP_NONE, 11'd1024, 11'd1024, 64'hffff_ffff_ffff_ffff, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd0, 11'd0, 64'h7fff_ffff_ffff_ffff, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd1, 11'd0, 64'h8000_0000_0000_0000, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 11'd0, 11'd2, 64'd0, CHK_FIXED, 64'hffff_ffff_ffff_ffff, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd1023, 11'd0, 64'hffff_ffff_ffff_ffff, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_ADD, 11'd1023, 11'd0, 64'd5, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 11'd1023, 11'd1024, 64'd0, CHK_FIXED, 64'd4, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd31, 11'd0, 64'h0123_4567_89ab_cdef, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd32, 11'd0, 64'hfedc_ba98_7654_3210, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd33, 11'd0, 64'd1000, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd64, 11'd0, 64'h8000_0000_0000_0001, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd33, 11'd0, 64'd77, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 11'd31, 11'd65, 64'd0, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_CFG, OP_LOAD, 11'd1, 11'd0, 64'd0, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd1, 11'd0, 64'd9, CHK_FIXED, 64'd0, 1'b1},
    '{ROW_ITEM, OP_QUERY, 11'd0, 11'd2, 64'd0, CHK_FIXED, 64'd0, 1'b1},
    '{ROW_ITEM, OP_QUERY, 11'd0, 11'd1, 64'd0, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_CFG, OP_LOAD, 11'd0, 11'd0, 64'd0, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd0, 11'd0, 64'd3, CHK_FIXED, 64'd0, 1'b1},
    '{ROW_ITEM, OP_QUERY, 11'd0, 11'd0, 64'd0, CHK_FIXED, 64'd0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 11'd0, 11'd1, 64'd0, CHK_FIXED, 64'd0, 1'b1},
    '{ROW_CFG, OP_LOAD, 11'd2047, 11'd0, 64'd0, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 11'd1024, 11'd1024, 64'd0, CHK_FIXED, 64'd0, 1'b0},
    '{ROW_ITEM, OP_LOAD, 11'd1023, 11'd0, 64'h5555_aaaa_5555_aaaa, CHK_MODEL, 64'd0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 11'd1023, 11'd1024, 64'd0, CHK_MODEL, 64'd0, 1'b0}
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [IDX_W-1:0]   cfg_wdata = '0;
  logic               s_valid   = 1'b0;
  logic [IN_TD_W-1:0] s_data    = '0;
  logic               m_ready   = 1'b0;
  wire                s_ready;
  wire                m_valid;
  wire  [DATA_W-1:0]  m_data;
  wire                m_user;

  // predictor state
  logic [DATA_W-1:0]  elem_mem     [DEPTH];
  bit                 elem_written [DEPTH];
  logic [DATA_W-1:0]  blk_total    [BLOCK_COUNT];
  int unsigned        written_list [$];
  logic [IDX_W-1:0]   count_reg    = COUNT_RESET;

  sum_result_t        result_q [$];
  int unsigned        mismatches  = 0;
  int unsigned        items_sent  = 0;
  int unsigned        stall_left  = 0;
  bit                 calm        = 1'b0;

  range_sum_block_decomposition u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #4 clk = ~clk;

  initial begin
    #8_000_000;
    $display("range_sum_block_decomposition: mismatch");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 64'h7fff_ffff_ffff_ffff;
      1:       return 64'h8000_0000_0000_0000;
      2:       return 64'hffff_ffff_ffff_ffff;
      3:       return 64'd0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int unsigned limit_now();
    return (count_reg > COUNT_MAX) ? DEPTH : int'(count_reg);
  endfunction

  function automatic logic [DATA_W-1:0] span_sum(input int unsigned from,
                                                 input int unsigned upto);
    logic [DATA_W-1:0] acc;
    int unsigned       i;
    acc = '0;
    for (i = from; i < upto && i < DEPTH; i++) acc += elem_mem[i];
    return acc;
  endfunction

  // returns 1 when the transfer produces a result
  function automatic bit predict_sum(input logic [OP_W-1:0] op,
                                     input int unsigned left, input int unsigned right,
                                     input logic [DATA_W-1:0] value,
                                     output sum_result_t res);
    int unsigned lim, lb, rb, b;
    res = '0;
    lim = limit_now();
    if (op == OP_LOAD || op == OP_ADD) begin
      if (left >= lim) begin
        res.err = 1'b1;
        return 1'b1;
      end
      if (op == OP_LOAD) elem_mem[left] = value;
      else               elem_mem[left] += value;
      if (!elem_written[left]) written_list.push_back(left);
      elem_written[left] = 1'b1;
      // block sum takes the value even when an element is overwritten
      blk_total[left / BLOCK_SIZE] += value;
      return 1'b0;
    end
    if (op == OP_QUERY) begin
      if (left > lim || right > lim) begin
        res.err = 1'b1;
        return 1'b1;
      end
      if (left < right) begin
        lb = left / BLOCK_SIZE;
        rb = right / BLOCK_SIZE;
        if (lb == rb) begin
          res.sum = span_sum(left, right);
        end else begin
          res.sum = span_sum(left, (lb + 1) * BLOCK_SIZE);
          for (b = lb + 1; b < rb; b++) res.sum += blk_total[b];
          res.sum += span_sum(rb * BLOCK_SIZE, right);
        end
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input int unsigned left,
                           input int unsigned right, input logic [DATA_W-1:0] value,
                           input bit fixed, input sum_result_t typed);
    sum_result_t res;
    bit          has;
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {value, IDX_W'(right), IDX_W'(left), op};
    has = predict_sum(op, left, right, value, res);
    if (fixed)    result_q.push_back(typed);
    else if (has) result_q.push_back(res);
    if (op != OP_NONE) items_sent++;
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [IDX_W-1:0] count);
    wait_drained();
    // a load still in flight gives no result, so let it finish first
    repeat (LAT_PAUSE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_reg = count;
  endtask

  // result side: random stalls, check every transfer against the oldest expectation
  always @(posedge clk) begin
    sum_result_t want;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result: sum %h error %b", m_data, m_user);
        end else begin
          want = result_q.pop_front();
          if (want.sum !== m_data || want.err !== m_user) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("sum expected %h got %h, error expected %b got %b",
                       want.sum, m_data, want.err, m_user);
          end
        end
      end
      if (calm) begin
        m_ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        if (stall_left != 0) begin
          stall_left--;
          m_ready <= 1'b0;
        end else begin
          m_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned       phase_cnt [8];
    int unsigned       quota, target, lim, left, right, lb, rb, i, tries, roll;
    sum_result_t       typed;
    dir_row_t          row;
    for (i = 0; i < DEPTH; i++) begin
      elem_mem[i]     = '0;
      elem_written[i] = 1'b0;
    end
    for (i = 0; i < BLOCK_COUNT; i++) blk_total[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      if (row.kind == ROW_CFG) begin
        write_count(row.left);
      end else begin
        typed.sum = row.x_sum;
        typed.err = row.x_err;
        send_item(row.op, row.left, row.right, row.value, row.chk == CHK_FIXED, typed);
      end
    end

    phase_cnt = '{1024, 1, $urandom_range(2, 1023), 2047, 0,
                  $urandom_range(2, 1023), 1024, $urandom_range(2, 40)};
    typed = '0;
    for (int p = 0; p < 8; p++) begin
      write_count(IDX_W'(phase_cnt[p]));
      calm   = (p == 3 || p == 6);
      lim    = limit_now();
      quota  = (phase_cnt[p] == 0) ? 20 : 110;
      target = items_sent + quota;
      while (items_sent < target) begin
        if ((p == 0 && items_sent == target - 60) || $urandom_range(0, 99) < 2)
          wait_drained();
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_item(OP_NONE, $urandom_range(0, 1024), $urandom_range(0, 1024),
                    rand_value(), 1'b0, typed);
        end else if (roll < 38) begin
          if (lim != 0 && $urandom_range(0, 4) != 0) left = $urandom_range(0, lim - 1);
          else                                      left = $urandom_range(0, 1024);
          send_item(OP_LOAD, left, $urandom_range(0, 1024), rand_value(), 1'b0, typed);
        end else if (roll < 58) begin
          // adds only touch elements already written, or fall out of bounds
          if (written_list.size() == 0) begin
            left = $urandom_range(lim, 1024);
          end else begin
            tries = 0;
            do begin
              left = written_list[$urandom_range(0, written_list.size() - 1)];
              tries++;
            end while (left >= lim && tries < 4);
          end
          send_item(OP_ADD, left, $urandom_range(0, 1024), rand_value(), 1'b0, typed);
        end else begin
          roll = $urandom_range(0, 9);
          if (roll < 7) begin
            left = $urandom_range(0, lim);
            if ($urandom_range(0, 1) == 0) right = $urandom_range(left, lim);
            else right = (left + $urandom_range(0, 40) > lim) ? lim
                                                              : left + $urandom_range(0, 40);
          end else if (roll < 8) begin
            left  = $urandom_range(0, lim);
            right = $urandom_range(0, left);
          end else begin
            left  = $urandom_range(0, 1024);
            right = $urandom_range(0, 1024);
          end
          // the edge blocks are read element by element, so they must hold data
          if (left <= lim && right <= lim && left < right) begin
            lb = left / BLOCK_SIZE;
            rb = right / BLOCK_SIZE;
            for (i = left; i < right; i++) begin
              if ((i / BLOCK_SIZE == lb || i / BLOCK_SIZE == rb) && !elem_written[i])
                send_item(OP_LOAD, i, $urandom_range(0, 1024), rand_value(), 1'b0, typed);
            end
          end
          send_item(OP_QUERY, left, right, rand_value(), 1'b0, typed);
        end
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (LAT_PAUSE) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("range_sum_block_decomposition: match");
    end else begin
      $display("range_sum_block_decomposition: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/rsbd_pkg.sv
rtl/core/rsbd_ram.sv
rtl/core/rsbd_datapath.sv
rtl/core/rsbd_ctrl.sv
rtl/core/range_sum_block_decomposition.sv
tb/range_sum_block_decomposition_tb.sv
